/* rtl/core/srpp_pkg.sv */
// Shared types and constants for the servo reply packet parser.
// No dependencies; compile this file first.

package srpp_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned WORD_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // Fixed header bytes of a short reply packet.
    localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'hFD;
    localparam logic [BYTE_W-1:0] HDR_SECOND = 8'hDF;

    // Reset values of the configuration registers.
    localparam logic [BYTE_W-1:0] RST_EXPECTED_ID    = 8'h01;
    localparam logic [BYTE_W-1:0] RST_EXPECTED_FLAGS = 8'h00;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPECTED_ID    = 2'd0,
        CFG_EXPECTED_FLAGS = 2'd1
    } t_cfg_idx;

    // Parser phase: where in the packet the next byte belongs.
    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_SECOND = 4'd1,
        PH_ID     = 4'd2,
        PH_FLAGS  = 4'd3,
        PH_ADDR   = 4'd4,
        PH_LEN    = 4'd5,
        PH_CNT    = 4'd6,
        PH_DLO    = 4'd7,
        PH_DHI    = 4'd8,
        PH_SUM    = 4'd9
    } t_phase;

endpackage

/* rtl/core/srpp_if.sv */
// Handshake channel interfaces for the servo reply packet parser.
// Depends on srpp_pkg for field widths.

interface srpp_rx_if;
    logic                        valid;
    logic                        ready;
    logic [srpp_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface srpp_reply_if;
    logic                        valid;
    logic                        ready;
    logic [srpp_pkg::BYTE_W-1:0] reg_address;
    logic [srpp_pkg::BYTE_W-1:0] reply_length;
    logic [srpp_pkg::BYTE_W-1:0] reply_count;
    logic [srpp_pkg::WORD_W-1:0] data_word;
    logic [srpp_pkg::BYTE_W-1:0] sum_byte;

    modport source (output valid, output reg_address, output reply_length,
                    output reply_count, output data_word, output sum_byte,
                    input ready);
    modport sink   (input valid, input reg_address, input reply_length,
                    input reply_count, input data_word, input sum_byte,
                    output ready);
endinterface

interface srpp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [srpp_pkg::CFG_IDX_W-1:0] reg_index;
    logic [srpp_pkg::BYTE_W-1:0]    wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

/* rtl/core/servo_reply_packet_parser.sv */
// Servo reply packet parser: top level, finds short reply packets in a byte stream.
// Depends on srpp_pkg and the channel interfaces in srpp_if.sv.
//
// Usage: received serial bytes enter on i_rx, one item per byte. The parser
// looks for the header 0xFD, 0xDF, expected id, expected flags, then captures
// address, length, count and two data bytes. The byte after those is the sum
// byte; on it one item leaves on o_reply carrying the captured fields and the
// sum byte, which is not checked. A 0xFD seen in place of a later header byte
// restarts the header; any other header mismatch drops back to idle.
// The expected id and flags are written through i_cfg (index 0 and 1); other
// indexes are ignored. The port is always ready and should only be written
// while no packet is in progress.
// Throughput is one byte per cycle. The phase update is a single compare and
// select, and the result register is loaded at the edge that accepts the sum
// byte, so the reply item is valid in the cycle after its sum byte is taken.
// When the receiver stalls, the result register holds its item and bytes keep
// flowing; only a sum byte waits, since it would need the busy result
// register. Reset (synchronous, active low) returns the parser to idle, empties
// the result register and restores id 1 and flags 0.

module servo_reply_packet_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    srpp_rx_if.sink             i_rx,
    srpp_reply_if.source        o_reply,
    srpp_cfg_if.sink            i_cfg
);
    import srpp_pkg::*;

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_expected_id;
    logic [BYTE_W-1:0] r_expected_flags;

    // Captured payload bytes of the packet in progress.
    logic [BYTE_W-1:0] r_held_address;
    logic [BYTE_W-1:0] r_held_length;
    logic [BYTE_W-1:0] r_held_count;
    logic [BYTE_W-1:0] r_held_data_low;
    logic [BYTE_W-1:0] r_held_data_high;

    // Result register toward the receiver.
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_address;
    logic [BYTE_W-1:0] r_out_length;
    logic [BYTE_W-1:0] r_out_count;
    logic [WORD_W-1:0] r_out_data;
    logic [BYTE_W-1:0] r_out_sum;

    logic rx_fire;
    logic emit;
    logic out_free;
    logic [BYTE_W-1:0] want_byte;

    // The result register can take a new item when it is empty or being drained.
    assign out_free   = !r_out_valid || o_reply.ready;
    assign i_rx.ready = out_free || (r_phase != PH_SUM);
    assign rx_fire    = i_rx.valid && i_rx.ready;
    assign emit       = rx_fire && (r_phase == PH_SUM);

    assign i_cfg.ready = 1'b1;

    // Byte the current header phase must see to advance.
    always_comb begin
        unique case (r_phase)
            PH_SECOND: want_byte = HDR_SECOND;
            PH_ID:     want_byte = r_expected_id;
            default:   want_byte = r_expected_flags;
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_rx.rx_byte == HDR_FIRST) begin
                    n_phase = PH_SECOND;
                end
            end
            PH_SECOND, PH_ID, PH_FLAGS: begin
                // A fresh 0xFD wins over the expected byte, even if they are equal.
                if (i_rx.rx_byte == HDR_FIRST) begin
                    n_phase = PH_SECOND;
                end else if (i_rx.rx_byte == want_byte) begin
                    n_phase = t_phase'(r_phase + 4'd1);
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_ADDR: n_phase = PH_LEN;
            PH_LEN:  n_phase = PH_CNT;
            PH_CNT:  n_phase = PH_DLO;
            PH_DLO:  n_phase = PH_DHI;
            PH_DHI:  n_phase = PH_SUM;
            PH_SUM:  n_phase = PH_IDLE;
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (rx_fire) begin
            r_phase <= n_phase;
        end
    end

    // Payload capture; these registers are always written before they are read.
    always_ff @(posedge i_clk) begin
        if (rx_fire) begin
            case (r_phase)
                PH_ADDR: r_held_address   <= i_rx.rx_byte;
                PH_LEN:  r_held_length    <= i_rx.rx_byte;
                PH_CNT:  r_held_count     <= i_rx.rx_byte;
                PH_DLO:  r_held_data_low  <= i_rx.rx_byte;
                PH_DHI:  r_held_data_high <= i_rx.rx_byte;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id    <= RST_EXPECTED_ID;
            r_expected_flags <= RST_EXPECTED_FLAGS;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.reg_index)
                CFG_EXPECTED_ID:    r_expected_id    <= i_cfg.wr_data;
                CFG_EXPECTED_FLAGS: r_expected_flags <= i_cfg.wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_reply.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_address <= r_held_address;
            r_out_length  <= r_held_length;
            r_out_count   <= r_held_count;
            r_out_data    <= {r_held_data_high, r_held_data_low};
            r_out_sum     <= i_rx.rx_byte;
        end
    end

    assign o_reply.valid        = r_out_valid;
    assign o_reply.reg_address  = r_out_address;
    assign o_reply.reply_length = r_out_length;
    assign o_reply.reply_count  = r_out_count;
    assign o_reply.data_word    = r_out_data;
    assign o_reply.sum_byte     = r_out_sum;

    // A sum byte is never taken while a stalled item sits in the result register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_reply.ready) |-> !emit)
        else $error("sum byte accepted over a stalled reply");

    // Accepting the sum byte presents a reply in the next cycle.
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> o_reply.valid)
        else $error("reply missing after sum byte");

    // After the sum byte the parser is back in idle.
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_phase == PH_IDLE))
        else $error("parser not idle after sum byte");

    // A new reply only appears after a sum byte was accepted.
    a_reply_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(emit))
        else $error("reply appeared without a sum byte");

endmodule
